// File: sv/dlpid_pkg.sv
package dlpid_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_KDT,
        ST_MUL_I,
        ST_INTEG,
        ST_DIFF,
        ST_MUL_D,
        ST_DERIV,
        ST_SUM,
        ST_PREP,
        ST_COMBINE,
        ST_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        MODE_PARALLEL = 2'd0,
        MODE_CASCADE  = 2'd1,
        MODE_YAW      = 2'd2,
        MODE_NONE     = 2'd3
    } loop_mode_t;

    localparam logic REQ_CLEAR = 1'b1;

    localparam int CFG_INDEX_W = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_P_GAIN    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_I_GAIN    = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_INT_LIMIT = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RATE_P_GAIN     = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RATE_I_GAIN     = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RATE_D_GAIN     = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_RATE_INT_LIMIT  = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_RATE_OUTPUT_MAX = 4'd7;

    localparam int WIDE_W = 44;
    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam wide_t WIDE_S32_MAX = 44'sd2147483647;
    localparam wide_t WIDE_S32_MIN = -44'sd2147483648;

    function automatic logic signed [31:0] sat32(input wide_t x);
        logic signed [31:0] r;
        if (x > WIDE_S32_MAX) begin
            r = WIDE_S32_MAX[31:0];
        end else if (x < WIDE_S32_MIN) begin
            r = WIDE_S32_MIN[31:0];
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_sym(input wide_t x, input logic [30:0] m);
        wide_t mw;
        wide_t nw;
        logic signed [31:0] r;
        mw = $signed({13'd0, m});
        nw = -mw;
        if (x > mw) begin
            r = mw[31:0];
        end else if (x < nw) begin
            r = nw[31:0];
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// File: sv/dual_loop_pid_controller.sv
// Channel  Direction  Ports                                             Handshake
// s_       in         req_type loop_mode error_value gyro_rate time_step s_valid/s_ready
// m_       out        drive_value                                       m_valid/m_ready
// cfg_     in         cfg_index cfg_data                                cfg_valid/cfg_ready
//
// One transaction is accepted in ST_IDLE and runs through one shared 33x33 multiplier
// under the sequencer: a loop runs ST_MUL_P, ST_MUL_KDT, ST_MUL_I, ST_INTEG and ST_SUM;
// the rate loop adds ST_DIFF, ST_MUL_D and ST_DERIV when its D gain is nonzero.
// Clear and none requests skip to ST_DONE; s_ready returns as the output register loads.
// aresetn clears the config registers, integrals, last error, m_valid and the sequencer; cfg_ready stays high.
// A stalled result holds in the output register; the sequencer waits in ST_DONE only when
// a second result is ready before the first is taken.
module dual_loop_pid_controller #(
    parameter int LEVEL_OUTPUT_MAX = 2147483647
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_req_type,
    input  logic [1:0]                        s_loop_mode,
    input  logic signed [31:0]                s_error_value,
    input  logic signed [31:0]                s_gyro_rate,
    input  logic [15:0]                       s_time_step,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [31:0]                m_drive_value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dlpid_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                       cfg_data
);
    import dlpid_pkg::*;

    localparam logic [30:0] LEVEL_MAX = 31'(LEVEL_OUTPUT_MAX);

    seq_state_t state_reg, state_next;

    logic [23:0] level_p_gain_reg, level_i_gain_reg;
    logic [30:0] level_int_limit_reg;
    logic [23:0] rate_p_gain_reg, rate_i_gain_reg, rate_d_gain_reg;
    logic [30:0] rate_int_limit_reg, rate_output_max_reg;

    loop_mode_t         mode_reg;
    logic signed [31:0] gyro_reg;
    logic [15:0]        dt_reg;
    logic               is_rate_reg;
    logic signed [31:0] e_reg;
    logic signed [65:0] prod_reg;
    logic signed [31:0] p_reg;
    logic signed [31:0] d_reg;
    logic signed [31:0] level_integral_reg;
    logic signed [31:0] rate_integral_reg;
    logic signed [31:0] rate_last_error_reg;
    logic signed [31:0] level_out_reg;
    logic signed [31:0] result_reg;
    logic               m_valid_reg;
    logic signed [31:0] drive_reg;

    logic               s_accept;
    logic               out_free;
    logic [23:0]        kp_sel, ki_sel;
    logic [30:0]        limit_sel, omax_sel;
    logic signed [31:0] integ_cur;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_prod;
    wide_t              scaled16;
    wide_t              integ_sum;
    wide_t              loop_sum;
    logic signed [31:0] integ_new;
    logic signed [31:0] loop_out;

    assign s_ready       = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_drive_value = drive_reg;
    assign s_accept      = s_valid && s_ready;
    assign out_free      = !m_valid_reg || m_ready;

    assign kp_sel    = is_rate_reg ? rate_p_gain_reg : level_p_gain_reg;
    assign ki_sel    = is_rate_reg ? rate_i_gain_reg : level_i_gain_reg;
    assign limit_sel = is_rate_reg ? rate_int_limit_reg : level_int_limit_reg;
    assign omax_sel  = is_rate_reg ? rate_output_max_reg : LEVEL_MAX;
    assign integ_cur = is_rate_reg ? rate_integral_reg : level_integral_reg;

    assign mul_prod  = 66'(mul_a) * 66'(mul_b);
    assign scaled16  = $signed(prod_reg[59:16]);
    assign integ_sum = wide_t'(integ_cur) + wide_t'($signed(prod_reg[65:24]));
    assign integ_new = clamp_sym(integ_sum, limit_sel);
    assign loop_sum  = wide_t'(p_reg) + wide_t'(integ_cur) + wide_t'(d_reg);
    assign loop_out  = clamp_sym(loop_sum, omax_sel);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_P: begin
                mul_a = $signed({9'd0, kp_sel});
                mul_b = {e_reg[31], e_reg};
            end
            ST_MUL_KDT: begin
                mul_a = $signed({9'd0, ki_sel});
                mul_b = $signed({17'd0, dt_reg});
            end
            ST_MUL_I: begin
                mul_a = {e_reg[31], e_reg};
                mul_b = $signed({1'b0, prod_reg[39:8]});
            end
            ST_MUL_D: begin
                mul_a = $signed({9'd0, rate_d_gain_reg});
                mul_b = {d_reg[31], d_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_req_type == REQ_CLEAR || loop_mode_t'(s_loop_mode) == MODE_NONE) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_MUL_P;
                    end
                end
            end
            ST_MUL_P:   state_next = ST_MUL_KDT;
            ST_MUL_KDT: state_next = ST_MUL_I;
            ST_MUL_I:   state_next = ST_INTEG;
            ST_INTEG: begin
                if (is_rate_reg && rate_d_gain_reg != 24'd0) begin
                    state_next = ST_DIFF;
                end else begin
                    state_next = ST_SUM;
                end
            end
            ST_DIFF:    state_next = ST_MUL_D;
            ST_MUL_D:   state_next = ST_DERIV;
            ST_DERIV:   state_next = ST_SUM;
            ST_SUM: begin
                if (!is_rate_reg) begin
                    state_next = ST_PREP;
                end else if (mode_reg == MODE_PARALLEL) begin
                    state_next = ST_COMBINE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_PREP:    state_next = ST_MUL_P;
            ST_COMBINE: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_p_gain_reg    <= '0;
            level_i_gain_reg    <= '0;
            level_int_limit_reg <= '0;
            rate_p_gain_reg     <= '0;
            rate_i_gain_reg     <= '0;
            rate_d_gain_reg     <= '0;
            rate_int_limit_reg  <= '0;
            rate_output_max_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_LEVEL_P_GAIN:    level_p_gain_reg    <= cfg_data[23:0];
                REG_LEVEL_I_GAIN:    level_i_gain_reg    <= cfg_data[23:0];
                REG_LEVEL_INT_LIMIT: level_int_limit_reg <= cfg_data[30:0];
                REG_RATE_P_GAIN:     rate_p_gain_reg     <= cfg_data[23:0];
                REG_RATE_I_GAIN:     rate_i_gain_reg     <= cfg_data[23:0];
                REG_RATE_D_GAIN:     rate_d_gain_reg     <= cfg_data[23:0];
                REG_RATE_INT_LIMIT:  rate_int_limit_reg  <= cfg_data[30:0];
                REG_RATE_OUTPUT_MAX: rate_output_max_reg <= cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_integral_reg  <= '0;
            rate_integral_reg   <= '0;
            rate_last_error_reg <= '0;
            is_rate_reg         <= 1'b0;
            mode_reg            <= MODE_NONE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        mode_reg <= loop_mode_t'(s_loop_mode);
                        gyro_reg <= s_gyro_rate;
                        dt_reg   <= s_time_step;
                        result_reg <= '0;
                        if (s_req_type == REQ_CLEAR) begin
                            level_integral_reg <= '0;
                            rate_integral_reg  <= '0;
                        end else if (loop_mode_t'(s_loop_mode) == MODE_YAW) begin
                            is_rate_reg <= 1'b1;
                            e_reg <= sat32(wide_t'(s_error_value) - wide_t'(s_gyro_rate));
                        end else begin
                            is_rate_reg <= 1'b0;
                            e_reg <= s_error_value;
                        end
                    end
                end
                ST_MUL_P: begin
                    prod_reg <= mul_prod;
                end
                ST_MUL_KDT: begin
                    p_reg    <= sat32(scaled16);
                    prod_reg <= mul_prod;
                end
                ST_MUL_I: begin
                    prod_reg <= mul_prod;
                end
                ST_INTEG: begin
                    d_reg <= '0;
                    if (is_rate_reg) begin
                        rate_integral_reg <= integ_new;
                    end else begin
                        level_integral_reg <= integ_new;
                    end
                end
                ST_DIFF: begin
                    d_reg <= sat32(wide_t'(e_reg) - wide_t'(rate_last_error_reg));
                end
                ST_MUL_D: begin
                    prod_reg <= mul_prod;
                end
                ST_DERIV: begin
                    d_reg               <= sat32(scaled16);
                    rate_last_error_reg <= e_reg;
                end
                ST_SUM: begin
                    if (is_rate_reg) begin
                        result_reg <= loop_out;
                    end else begin
                        level_out_reg <= loop_out;
                    end
                end
                ST_PREP: begin
                    is_rate_reg <= 1'b1;
                    if (mode_reg == MODE_PARALLEL) begin
                        e_reg <= sat32(-wide_t'(gyro_reg));
                    end else begin
                        e_reg <= sat32(wide_t'(level_out_reg) - wide_t'(gyro_reg));
                    end
                end
                ST_COMBINE: begin
                    result_reg <= sat32(wide_t'(level_out_reg) + wide_t'(result_reg));
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
            drive_reg   <= result_reg;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

endmodule

// File: tb/dual_loop_pid_controller_tb.sv
`timescale 1ns / 100ps

module dual_loop_pid_controller_tb;
    import dlpid_pkg::*;

    localparam int LEVEL_MAX = 2147483647;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 250;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 20;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = REG_RATE_OUTPUT_MAX + 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = '1;

    localparam logic REQ_STEP = 1'b0;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh80000000;
    localparam logic signed [31:0] VAL_ONE = 32'sh00010000;
    localparam logic [15:0] DT_MAX = 16'hFFFF;
    localparam logic [23:0] GAIN_MAX = 24'hFFFFFF;
    localparam logic [23:0] GAIN_ONE = 24'h010000;
    localparam logic [30:0] BOUND_MAX = 31'h7FFFFFFF;
    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483648;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_BURSTY} rx_style_t;

    typedef struct {
        logic signed [31:0] drive;
        int                 seq;
    } drive_expect_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_req_type;
    logic [1:0]             s_loop_mode;
    logic signed [31:0]     s_error_value;
    logic signed [31:0]     s_gyro_rate;
    logic [15:0]            s_time_step;
    logic                   m_valid;
    logic                   m_ready;
    logic signed [31:0]     m_drive_value;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]            cfg_data;

    // controller shadow: registers and loop state
    logic [23:0] lvl_kp, lvl_ki, rate_kp, rate_ki, rate_kd;
    logic [30:0] lvl_bound, rate_bound, rate_out_max;
    longint      lvl_integ, rate_integ, rate_last_err;

    drive_expect_t drive_q[$];

    int n_items = 0;
    int n_checked = 0;
    int n_clear = 0;
    int n_cfg = 0;
    int n_errors = 0;
    int mode_hits[4] = '{0, 0, 0, 0};

    bit         tx_steady = 1'b0;
    int         tx_burst_left = 0;
    int         hold_request = 0;
    loop_mode_t run_mode = MODE_PARALLEL;
    logic signed [31:0] run_err = '0;
    logic signed [31:0] run_gyro = '0;
    int         run_left = 0;

    dual_loop_pid_controller #(
        .LEVEL_OUTPUT_MAX(LEVEL_MAX)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_loop_mode  (s_loop_mode),
        .s_error_value(s_error_value),
        .s_gyro_rate  (s_gyro_rate),
        .s_time_step  (s_time_step),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_drive_value(m_drive_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        aclk = 1'b0;
    end

    always #5 aclk = ~aclk;

    function automatic longint sat_s32(input longint x);
        if (x > S32_HI) return S32_HI;
        if (x < S32_LO) return S32_LO;
        return x;
    endfunction

    function automatic longint clip_sym(input longint x, input longint m);
        if (x > m) return m;
        if (x < -m) return -m;
        return x;
    endfunction

    function automatic longint loop_output(input longint e, input longint kp, input longint ki,
                                           input longint kd, input longint bound,
                                           input longint out_max, input longint dt,
                                           inout longint integ, inout longint last,
                                           input bit with_d);
        longint p;
        longint kdt;
        longint d;
        p = sat_s32((kp * e) >>> 16);
        kdt = (ki * dt) >>> 8;
        integ = clip_sym(integ + ((e * kdt) >>> 24), bound);
        d = 0;
        if (with_d && kd != 0) begin
            d = sat_s32((kd * sat_s32(e - last)) >>> 16);
            last = e;
        end
        return clip_sym(p + integ + d, out_max);
    endfunction

    function automatic longint level_output(input longint e, input longint dt);
        longint no_last;
        no_last = 0;
        return loop_output(e, longint'(lvl_kp), longint'(lvl_ki), 64'sd0,
                           longint'(lvl_bound), longint'(LEVEL_MAX), dt,
                           lvl_integ, no_last, 1'b0);
    endfunction

    function automatic longint rate_output(input longint e, input longint dt);
        return loop_output(e, longint'(rate_kp), longint'(rate_ki), longint'(rate_kd),
                           longint'(rate_bound), longint'(rate_out_max), dt,
                           rate_integ, rate_last_err, 1'b1);
    endfunction

    function automatic logic signed [31:0] predict_drive(input logic req, input loop_mode_t mode,
                                                         input logic signed [31:0] err,
                                                         input logic signed [31:0] gyro,
                                                         input logic [15:0] dt);
        longint lvl_out;
        longint drive;
        drive = 0;
        if (req == REQ_CLEAR) begin
            lvl_integ = 0;
            rate_integ = 0;
        end else begin
            case (mode)
                MODE_PARALLEL: begin
                    lvl_out = level_output(longint'(err), longint'(dt));
                    drive = sat_s32(lvl_out + rate_output(sat_s32(-longint'(gyro)),
                                                          longint'(dt)));
                end
                MODE_CASCADE: begin
                    lvl_out = level_output(longint'(err), longint'(dt));
                    drive = rate_output(sat_s32(lvl_out - longint'(gyro)), longint'(dt));
                end
                MODE_YAW: begin
                    drive = rate_output(sat_s32(longint'(err) - longint'(gyro)),
                                        longint'(dt));
                end
                default: begin
                    drive = 0;
                end
            endcase
        end
        return drive[31:0];
    endfunction

    task automatic report_mismatch(input string what);
        n_errors++;
        if (n_errors <= 50) begin
            $display("%0t MISMATCH: %s", $time, what);
        end
    endtask

    function automatic int next_gap();
        if (tx_burst_left > 0) begin
            tx_burst_left--;
            return 0;
        end
        tx_burst_left = $urandom_range(1, 24);
        if (tx_steady) return 0;
        return $urandom_range(1, 6);
    endfunction

    task automatic send_item(input logic req, input loop_mode_t mode,
                             input logic signed [31:0] err, input logic signed [31:0] gyro,
                             input logic [15:0] dt);
        int gap;
        drive_expect_t entry;
        gap = next_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_req_type = req;
        s_loop_mode = mode;
        s_error_value = err;
        s_gyro_rate = gyro;
        s_time_step = dt;
        do @(posedge aclk); while (!s_ready);
        entry.drive = predict_drive(req, mode, err, gyro, dt);
        entry.seq = n_items;
        drive_q.push_back(entry);
        n_items++;
        if (req == REQ_CLEAR) n_clear++;
        else mode_hits[mode]++;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (drive_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_LEVEL_P_GAIN:    lvl_kp = data[23:0];
            REG_LEVEL_I_GAIN:    lvl_ki = data[23:0];
            REG_LEVEL_INT_LIMIT: lvl_bound = data[30:0];
            REG_RATE_P_GAIN:     rate_kp = data[23:0];
            REG_RATE_I_GAIN:     rate_ki = data[23:0];
            REG_RATE_D_GAIN:     rate_kd = data[23:0];
            REG_RATE_INT_LIMIT:  rate_bound = data[30:0];
            REG_RATE_OUTPUT_MAX: rate_out_max = data[30:0];
            default: ;
        endcase
        n_cfg++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_gains(input logic [31:0] lp, input logic [31:0] li, input logic [31:0] ll,
                             input logic [31:0] rp, input logic [31:0] ri, input logic [31:0] rd,
                             input logic [31:0] rl, input logic [31:0] rm);
        logic [CFG_INDEX_W-1:0] stray;
        drain_results();
        write_reg(REG_LEVEL_P_GAIN, lp);
        write_reg(REG_LEVEL_I_GAIN, li);
        write_reg(REG_LEVEL_INT_LIMIT, ll);
        write_reg(REG_RATE_P_GAIN, rp);
        write_reg(REG_RATE_I_GAIN, ri);
        write_reg(REG_RATE_D_GAIN, rd);
        write_reg(REG_RATE_INT_LIMIT, rl);
        write_reg(REG_RATE_OUTPUT_MAX, rm);
        if ($urandom_range(0, 1) == 0) begin
            stray = CFG_INDEX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI));
            write_reg(stray, $urandom);
        end
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2, 3: return $urandom;
            4: return int'($urandom_range(0, 511)) - 256;
            default: return int'($urandom_range(0, 32'h200000)) - 32'sh100000;
        endcase
    endfunction

    function automatic logic [15:0] pick_dt();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return DT_MAX;
            2, 3: return 16'($urandom_range(1, 64));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        logic [23:0] g;
        case ($urandom_range(0, 5))
            0: g = '0;
            1: g = GAIN_MAX;
            2: g = 24'($urandom);
            default: g = 24'($urandom_range(0, 32'h30000));
        endcase
        return {8'($urandom), g};
    endfunction

    function automatic logic [31:0] pick_bound();
        logic [30:0] b;
        case ($urandom_range(0, 5))
            0: b = '0;
            1: b = BOUND_MAX;
            2: b = 31'($urandom);
            3: b = 31'($urandom_range(1, 32'h400000));
            default: b = 31'($urandom_range(32'h10000, 32'h4000000));
        endcase
        return {1'($urandom), b};
    endfunction

    task automatic send_random_item();
        logic req;
        loop_mode_t mode;
        logic signed [31:0] err;
        logic signed [31:0] gyro;
        if (run_left == 0) begin
            run_mode = loop_mode_t'($urandom_range(0, 3));
            run_err = pick_value();
            run_gyro = pick_value();
            run_left = $urandom_range(1, 40);
        end
        run_left--;
        req = ($urandom_range(0, 29) == 0);
        mode = ($urandom_range(0, 4) == 0) ? loop_mode_t'($urandom_range(0, 3)) : run_mode;
        if ($urandom_range(0, 4) == 0) err = pick_value();
        else err = run_err + (int'($urandom_range(0, 8191)) - 4096);
        if ($urandom_range(0, 4) == 0) gyro = pick_value();
        else gyro = run_gyro + (int'($urandom_range(0, 8191)) - 4096);
        send_item(req, mode, err, gyro, pick_dt());
    endtask

    task automatic test_zero_config();
        send_item(REQ_STEP, MODE_PARALLEL, VAL_MAX, VAL_MIN, DT_MAX);
        send_item(REQ_STEP, MODE_CASCADE, VAL_MIN, VAL_MAX, DT_MAX);
        send_item(REQ_STEP, MODE_YAW, VAL_MAX, VAL_MIN, DT_MAX);
        send_item(REQ_STEP, MODE_NONE, VAL_MIN, VAL_MIN, 16'd0);
        send_item(REQ_CLEAR, MODE_YAW, VAL_MAX, VAL_MAX, DT_MAX);
    endtask

    task automatic test_directed_extremes();
        set_gains(32'(GAIN_ONE), 32'(GAIN_MAX), 32'(BOUND_MAX), 32'(GAIN_MAX), 32'h00008000,
                  32'(GAIN_MAX), 32'h00010000, 32'(BOUND_MAX));
        send_item(REQ_STEP, MODE_PARALLEL, VAL_MAX, VAL_MIN, DT_MAX);
        send_item(REQ_STEP, MODE_PARALLEL, VAL_MIN, VAL_MAX, DT_MAX);
        send_item(REQ_STEP, MODE_CASCADE, VAL_MAX, VAL_MAX, 16'd0);
        send_item(REQ_STEP, MODE_CASCADE, VAL_MIN, VAL_MIN, 16'd1);
        send_item(REQ_STEP, MODE_YAW, VAL_MAX, VAL_MIN, DT_MAX);
        send_item(REQ_STEP, MODE_YAW, -32'sd1, 32'sd0, 16'd1);
        send_item(REQ_STEP, MODE_NONE, VAL_MAX, VAL_MIN, DT_MAX);
        send_item(REQ_CLEAR, MODE_CASCADE, VAL_MIN, VAL_MAX, DT_MAX);
        send_item(REQ_STEP, MODE_YAW, 32'sd0, 32'sd0, DT_MAX);
    endtask

    task automatic test_derivative_disable();
        set_gains(32'h00008000, 32'h00004000, 32'h00100000, 32'h00020000, 32'h00001000,
                  32'h0, 32'h0, 32'h0);
        send_item(REQ_STEP, MODE_YAW, 32'sh00050000, 32'sd0, 16'h0100);
        send_item(REQ_STEP, MODE_YAW, -32'sh00030000, VAL_ONE, 16'h0100);
        drain_results();
        write_reg(REG_RATE_D_GAIN, 32'(GAIN_ONE));
        write_reg(REG_RATE_OUTPUT_MAX, 32'(BOUND_MAX));
        write_reg(REG_UNUSED_HI, '1);
        send_item(REQ_STEP, MODE_YAW, VAL_ONE, -32'sh00020000, 16'h0100);
        send_item(REQ_STEP, MODE_YAW, VAL_ONE, -32'sh00020000, 16'h0100);
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: set_gains(32'(GAIN_MAX), 32'(GAIN_MAX), 32'(BOUND_MAX), 32'(GAIN_MAX),
                             32'(GAIN_MAX), 32'(GAIN_MAX), 32'(BOUND_MAX), 32'(BOUND_MAX));
                1: set_gains(32'(GAIN_MAX), 32'(GAIN_MAX), '0, 32'(GAIN_MAX),
                             32'(GAIN_MAX), 32'(GAIN_MAX), '0, '0);
                default: set_gains(pick_gain(), pick_gain(), pick_bound(), pick_gain(),
                                   pick_gain(), pick_gain(), pick_bound(), pick_bound());
            endcase
            tx_steady = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS) send_random_item();
        end
        tx_steady = 1'b0;
    endtask

    task automatic test_output_backpressure();
        drain_results();
        tx_steady = 1'b1;
        hold_request = HOLD_CYCLES;
        repeat (40) send_random_item();
        tx_steady = 1'b0;
    endtask

    initial begin : result_sink
        rx_style_t rx_style;
        int style_left;
        int stall_left;
        int hold_left;
        int tick;
        rx_style = RX_ALWAYS;
        style_left = 0;
        stall_left = 0;
        hold_left = 0;
        tick = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            tick++;
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                if (style_left == 0) begin
                    rx_style = rx_style_t'($urandom_range(0, 3));
                    style_left = $urandom_range(50, 400);
                end
                style_left--;
                case (rx_style)
                    RX_ALWAYS:   m_ready = 1'b1;
                    RX_COIN:     m_ready = 1'($urandom_range(0, 1));
                    RX_PERIODIC: m_ready = (tick % 7) < 3;
                    default: begin
                        if (stall_left > 0) begin
                            m_ready = 1'b0;
                            stall_left--;
                        end else begin
                            m_ready = 1'b1;
                            if ($urandom_range(0, 19) == 0) stall_left = $urandom_range(4, 16);
                        end
                    end
                endcase
            end
        end
    end

    always @(posedge aclk) begin : drive_check
        drive_expect_t want;
        if (aresetn && m_valid && m_ready) begin
            n_checked++;
            if (drive_q.size() == 0) begin
                report_mismatch($sformatf("drive_value %0d with no transaction pending",
                                          m_drive_value));
            end else begin
                want = drive_q.pop_front();
                if (m_drive_value !== want.drive) begin
                    report_mismatch($sformatf("transaction %0d drive_value %0d, want %0d",
                                              want.seq, m_drive_value, want.drive));
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d results outstanding", drive_q.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req_type = 1'b0;
        s_loop_mode = MODE_PARALLEL;
        s_error_value = '0;
        s_gyro_rate = '0;
        s_time_step = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        lvl_kp = '0;
        lvl_ki = '0;
        lvl_bound = '0;
        rate_kp = '0;
        rate_ki = '0;
        rate_kd = '0;
        rate_bound = '0;
        rate_out_max = '0;
        lvl_integ = 0;
        rate_integ = 0;
        rate_last_err = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_zero_config();
        test_directed_extremes();
        test_derivative_disable();
        test_random_phases();
        test_output_backpressure();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Ran %0d transactions: %0d clear, %0d parallel, %0d cascade, %0d yaw, %0d none",
                 n_items, n_clear, mode_hits[MODE_PARALLEL], mode_hits[MODE_CASCADE],
                 mode_hits[MODE_YAW], mode_hits[MODE_NONE]);
        $display("Checked %0d drive values over %0d register writes, %0d mismatches",
                 n_checked, n_cfg, n_errors);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/dlpid_pkg.sv
sv/dual_loop_pid_controller.sv
tb/dual_loop_pid_controller_tb.sv
